[design/dvru_pkg.sv]
// Shared types and constants for the distance-vector route update block.
// Used by dvru_front, dvru_back and the top level; depends on nothing.
package dvru_pkg;

  // Request kinds
  localparam logic KIND_ADVERT  = 1'b0;
  localparam logic KIND_INSTALL = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_UNCHANGED = 2'd0;
  localparam logic [1:0] ST_UPDATED   = 2'd1;
  localparam logic [1:0] ST_INSERTED  = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  localparam logic [7:0] COST_ONE = 8'd1;
  localparam logic [7:0] COST_MAX = 8'd255;

  typedef struct packed {
    logic        kind;
    logic [31:0] sender_addr;
    logic [31:0] iface_addr;
    logic [31:0] dest_addr;
    logic [7:0]  adv_cost;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot;
    logic [7:0]  route_cost;
    logic [31:0] route_next_hop;
  } result_t;

  // Classified request as held in the queue between front and back
  typedef struct packed {
    req_t        req;
    logic [7:0]  relaxed_cost;
    logic        self_route;
  } work_t;

endpackage

[design/dvru_front.sv]
// Front end: accepts requests, classifies them and queues them for the back end.
// Depends on dvru_pkg (req_t, work_t, COST_MAX).
module dvru_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv_valid,
  output logic           adv_ready,
  input  dvru_pkg::req_t adv,
  output logic           q_valid,
  input  logic           q_pop,
  output dvru_pkg::work_t q_item
);

  dvru_pkg::work_t slots [2];
  dvru_pkg::work_t classified;
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      fill;
  logic            push;

  always_comb begin
    classified.req          = adv;
    classified.relaxed_cost = (adv.adv_cost == dvru_pkg::COST_MAX) ?
                              dvru_pkg::COST_MAX : adv.adv_cost + dvru_pkg::COST_ONE;
    classified.self_route   = (adv.sender_addr == adv.dest_addr);
  end

  assign adv_ready = (fill != 2'd2);
  assign push      = adv_valid && adv_ready;
  assign q_valid   = (fill != 2'd0);
  assign q_item    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, q_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

[design/dvru_back.sv]
// Back end: scans the route table for the destination, then updates the match or appends
// (or reports a full table) and registers the result. Depends on dvru_pkg (work_t, result_t, status codes).
module dvru_back #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_pop,
  input  dvru_pkg::work_t   q_item,
  output logic              result_valid,
  input  logic              result_ready,
  output dvru_pkg::result_t result
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPD,
    S_APP
  } state_t;

  // Route table
  logic [31:0] dest_mem  [TABLE_DEPTH];
  logic [31:0] hop_mem   [TABLE_DEPTH];
  logic [31:0] iface_mem [TABLE_DEPTH];
  logic [7:0]  cost_mem  [TABLE_DEPTH];

  state_t          state;
  dvru_pkg::work_t item;
  logic [CW-1:0]   count;
  logic [CW-1:0]   idx;
  logic [AW-1:0]   cmp_idx;
  logic            cmp_vld;
  logic [31:0]     dest_q;
  logic [31:0]     hop_q;
  logic [7:0]      cost_q;
  logic [AW-1:0]   slot_q;

  logic              out_free;
  logic              hit;
  logic              issue;
  logic              full;
  logic              finish;
  logic              hop_we;
  logic              iface_we;
  logic              dest_we;
  logic [AW-1:0]     wr_addr;
  logic [31:0]       wr_hop;
  logic [7:0]        wr_cost;
  dvru_pkg::result_t result_next;
  logic              take;

  always_comb begin
    out_free = !result_valid || result_ready;
    hit      = (state == S_SCAN) && cmp_vld && (dest_q == item.req.dest_addr);
    issue    = (state == S_SCAN) && !hit && (idx < count);
    full     = (count == CW'(TABLE_DEPTH));
    q_pop    = (state == S_IDLE) && q_valid;
    take     = (cost_q > item.relaxed_cost) || (hop_q == item.req.sender_addr);

    hop_we      = 1'b0;
    iface_we    = 1'b0;
    dest_we     = 1'b0;
    wr_addr     = slot_q;
    wr_hop      = item.req.sender_addr;
    wr_cost     = item.relaxed_cost;
    result_next = '0;

    case (state)
      S_UPD: begin
        result_next.slot = 4'(slot_q);
        if (item.req.kind == dvru_pkg::KIND_INSTALL) begin
          hop_we   = 1'b1;
          iface_we = 1'b1;
          wr_cost  = item.req.adv_cost;
          result_next.status = dvru_pkg::ST_UPDATED;
        end else if (take) begin
          hop_we = 1'b1;
          result_next.status = dvru_pkg::ST_UPDATED;
        end else begin
          wr_hop  = hop_q;
          wr_cost = cost_q;
          result_next.status = dvru_pkg::ST_UNCHANGED;
        end
        result_next.route_cost     = wr_cost;
        result_next.route_next_hop = wr_hop;
      end
      S_APP: begin
        wr_addr = count[AW-1:0];
        if (full) begin
          result_next.status = dvru_pkg::ST_FULL;
        end else begin
          hop_we   = 1'b1;
          iface_we = 1'b1;
          dest_we  = 1'b1;
          if (item.req.kind == dvru_pkg::KIND_INSTALL) begin
            wr_cost = item.req.adv_cost;
          end else if (item.self_route) begin
            wr_cost = dvru_pkg::COST_ONE;
          end
          result_next.status         = dvru_pkg::ST_INSERTED;
          result_next.slot           = 4'(count[AW-1:0]);
          result_next.route_cost     = wr_cost;
          result_next.route_next_hop = wr_hop;
        end
      end
      default: begin
        result_next = '0;
      end
    endcase

    finish = ((state == S_UPD) || (state == S_APP)) && out_free;
  end

  // Table ports: one scan read, one entry read on a hit, one write
  always_ff @(posedge clk) begin
    if (issue) begin
      dest_q <= dest_mem[idx[AW-1:0]];
    end
    if (hit) begin
      hop_q  <= hop_mem[cmp_idx];
      cost_q <= cost_mem[cmp_idx];
      slot_q <= cmp_idx;
    end
    if (finish && dest_we) begin
      dest_mem[wr_addr] <= item.req.dest_addr;
    end
    if (finish && hop_we) begin
      hop_mem[wr_addr]  <= wr_hop;
      cost_mem[wr_addr] <= wr_cost;
    end
    if (finish && iface_we) begin
      iface_mem[wr_addr] <= item.req.iface_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      idx          <= '0;
      cmp_vld      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            item    <= q_item;
            idx     <= '0;
            cmp_vld <= 1'b0;
            state   <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (hit) begin
            state <= S_UPD;
          end else if (issue) begin
            cmp_vld <= 1'b1;
            cmp_idx <= idx[AW-1:0];
            idx     <= idx + CW'(1);
          end else begin
            state <= S_APP;
          end
        end
        S_UPD, S_APP: begin
          if (finish) begin
            result       <= result_next;
            result_valid <= 1'b1;
            if (dest_we) begin
              count <= count + CW'(1);
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH))
    else $error("route count beyond table depth");

  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status == dvru_pkg::ST_FULL) |->
      (result.slot == 4'd0) && (result.route_cost == 8'd0) &&
      (result.route_next_hop == 32'd0))
    else $error("table-full result carries nonzero fields");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    finish && dest_we |=> count == $past(count) + CW'(1))
    else $error("append did not grow the table by one");

  a_no_write_when_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_APP) && full |-> !dest_we && !hop_we && !iface_we)
    else $error("write into a full table");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state == S_SCAN) && (idx == '0) && !cmp_vld)
    else $error("scan did not restart after a pop");

endmodule

[design/distance_vector_route_update.sv]
// Top level of the distance-vector route update block: front queue plus back end.
// Depends on dvru_pkg, dvru_front and dvru_back.
//
//   channel  | signals                                | direction
//   ---------+----------------------------------------+----------
//   request  | adv_valid, adv_ready, adv (req_t)       | in
//   result   | result_valid, result_ready, result      | out
//
// A request that matches slot s ends its scan at slot s; one that misses scans all n
// routes held. The back end scans the destination memory one entry per cycle, so
// its time per request grows with s or n. Reset empties the table at once, with no
// clearing pass. A two-deep queue keeps taking requests while the back end scans,
// and the result register lets the back end take and scan the next request while a
// result waits, though it holds before writing until that result is taken.
module distance_vector_route_update #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv_valid,
  output logic              adv_ready,
  input  dvru_pkg::req_t    adv,
  output logic              result_valid,
  input  logic              result_ready,
  output dvru_pkg::result_t result
);

  logic            q_valid;
  logic            q_pop;
  dvru_pkg::work_t q_item;

  dvru_front u_front (
    .clk       (clk),
    .rst       (rst),
    .adv_valid (adv_valid),
    .adv_ready (adv_ready),
    .adv       (adv),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item)
  );

  dvru_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_item       (q_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

[dv/testbench.sv]
// Testbench for distance_vector_route_update: a directed table of route requests,
// then random advertisements and installs checked against a route-table model kept here.
// Depends on dvru_pkg and the distance_vector_route_update top level.
module testbench;

  localparam int DEPTH       = 16;
  localparam int RAND_ITEMS  = 1800;
  localparam int LIMIT_TICKS = 4000000;

  typedef struct {
    dvru_pkg::req_t    req;
    bit                typed;
    dvru_pkg::result_t want;
  } stim_row_t;

  logic              clk;
  logic              rst;
  logic              adv_valid;
  logic              adv_ready;
  dvru_pkg::req_t    adv;
  logic              result_valid;
  logic              result_ready;
  dvru_pkg::result_t result;

  // route table as the block should hold it
  logic [31:0] rt_dest [DEPTH];
  logic [31:0] rt_hop [DEPTH];
  logic [31:0] rt_iface [DEPTH];
  logic [7:0]  rt_cost [DEPTH];
  int          rt_count;

  dvru_pkg::result_t pending_routes[$];
  stim_row_t         stim_rows[$];
  int                mismatch_count;
  int                stall_left;
  bit                quiet;

  distance_vector_route_update #(.TABLE_DEPTH(DEPTH)) uut (
    .clk          (clk),
    .rst          (rst),
    .adv_valid    (adv_valid),
    .adv_ready    (adv_ready),
    .adv          (adv),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #2 clk = ~clk;

  function automatic dvru_pkg::req_t mk_req(logic kind, logic [31:0] sender,
                                            logic [31:0] iface, logic [31:0] dest,
                                            logic [7:0] cost);
    dvru_pkg::req_t r;
    r.kind        = kind;
    r.sender_addr = sender;
    r.iface_addr  = iface;
    r.dest_addr   = dest;
    r.adv_cost    = cost;
    return r;
  endfunction

  function automatic dvru_pkg::result_t mk_res(logic [1:0] status, logic [3:0] slot,
                                               logic [7:0] cost, logic [31:0] hop);
    dvru_pkg::result_t r;
    r.status         = status;
    r.slot           = slot;
    r.route_cost     = cost;
    r.route_next_hop = hop;
    return r;
  endfunction

  function automatic void add_row(dvru_pkg::req_t r, bit typed, dvru_pkg::result_t want);
    stim_row_t row;
    row.req   = r;
    row.typed = typed;
    row.want  = want;
    stim_rows.insert(stim_rows.size(), row);
  endfunction

  // Apply one request to the local table and return the result it should produce.
  function automatic dvru_pkg::result_t route_predict(dvru_pkg::req_t r);
    dvru_pkg::result_t res;
    logic [7:0]        relaxed;
    int                hit;
    res     = '0;
    relaxed = (r.adv_cost == dvru_pkg::COST_MAX) ? dvru_pkg::COST_MAX : r.adv_cost + 8'd1;
    hit     = -1;
    for (int i = 0; i < rt_count; i++) begin
      if (hit < 0 && rt_dest[i] == r.dest_addr) hit = i;
    end
    if (hit >= 0) begin
      if (r.kind == dvru_pkg::KIND_INSTALL) begin
        rt_hop[hit]   = r.sender_addr;
        rt_iface[hit] = r.iface_addr;
        rt_cost[hit]  = r.adv_cost;
        res.status    = dvru_pkg::ST_UPDATED;
      end else if (rt_cost[hit] > relaxed || rt_hop[hit] == r.sender_addr) begin
        rt_cost[hit] = relaxed;
        rt_hop[hit]  = r.sender_addr;
        res.status   = dvru_pkg::ST_UPDATED;
      end else begin
        res.status = dvru_pkg::ST_UNCHANGED;
      end
      res.slot           = 4'(hit);
      res.route_cost     = rt_cost[hit];
      res.route_next_hop = rt_hop[hit];
    end else if (rt_count >= DEPTH) begin
      res.status = dvru_pkg::ST_FULL;
    end else begin
      rt_dest[rt_count]  = r.dest_addr;
      rt_hop[rt_count]   = r.sender_addr;
      rt_iface[rt_count] = r.iface_addr;
      if (r.kind == dvru_pkg::KIND_INSTALL) rt_cost[rt_count] = r.adv_cost;
      else if (r.sender_addr == r.dest_addr) rt_cost[rt_count] = dvru_pkg::COST_ONE;
      else rt_cost[rt_count] = relaxed;
      res.status         = dvru_pkg::ST_INSERTED;
      res.slot           = 4'(rt_count);
      res.route_cost     = rt_cost[rt_count];
      res.route_next_hop = rt_hop[rt_count];
      rt_count++;
    end
    return res;
  endfunction

  // Mostly short gaps, now and then a long one; none while quiet.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 8);
    return $urandom_range(20, 40);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Entered and left just after a falling edge.
  task automatic send_req(dvru_pkg::req_t r, bit typed, dvru_pkg::result_t want);
    int                gap;
    dvru_pkg::result_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      adv_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    adv_valid <= 1'b1;
    adv       <= r;
    do @(posedge clk); while (!adv_ready);
    predicted = route_predict(r);
    pending_routes.insert(pending_routes.size(), typed ? want : predicted);
    @(negedge clk);
  endtask

  function automatic dvru_pkg::req_t random_req();
    logic        kind;
    logic [31:0] sender;
    logic [31:0] dest;
    logic [7:0]  cost;
    int          roll;
    kind = ($urandom_range(0, 99) < 20) ? dvru_pkg::KIND_INSTALL : dvru_pkg::KIND_ADVERT;
    roll = $urandom_range(0, 99);
    if (roll < 85 && rt_count > 0) dest = rt_dest[$urandom_range(0, rt_count - 1)];
    else dest = $urandom;
    roll = $urandom_range(0, 99);
    if (roll < 30 && rt_count > 0) sender = rt_hop[$urandom_range(0, rt_count - 1)];
    else if (roll < 55) sender = 32'h0A00_0000 + $urandom_range(0, 3);
    else if (roll < 60) sender = dest;
    else sender = $urandom;
    roll = $urandom_range(0, 99);
    if (roll < 10) cost = 8'd0;
    else if (roll < 20) cost = dvru_pkg::COST_MAX;
    else if (roll < 30) cost = 8'd254;
    else if (roll < 60) cost = 8'($urandom_range(0, 15));
    else cost = 8'($urandom);
    return mk_req(kind, sender, $urandom, dest, cost);
  endfunction

  // result side: random stalls, checked at the rising edge
  always @(negedge clk) begin
    int roll;
    if (stall_left > 0) begin
      result_ready <= 1'b0;
      stall_left--;
    end else begin
      result_ready <= 1'b1;
      roll = $urandom_range(0, 99);
      if (!quiet && !rst) begin
        if (roll < 25) stall_left = $urandom_range(1, 3);
        else if (roll < 28) stall_left = $urandom_range(20, 40);
      end
    end
  end

  always @(posedge clk) begin
    dvru_pkg::result_t exp_r;
    if (!rst && result_valid && result_ready) begin
      if (pending_routes.size() == 0) begin
        report_mismatch("unexpected result", 32'd1, 32'd0);
      end else begin
        exp_r = pending_routes.pop_front();
        if (result.status !== exp_r.status)
          report_mismatch("status", 32'(result.status), 32'(exp_r.status));
        if (result.slot !== exp_r.slot)
          report_mismatch("slot", 32'(result.slot), 32'(exp_r.slot));
        if (result.route_cost !== exp_r.route_cost)
          report_mismatch("route_cost", 32'(result.route_cost), 32'(exp_r.route_cost));
        if (result.route_next_hop !== exp_r.route_next_hop)
          report_mismatch("route_next_hop", result.route_next_hop, exp_r.route_next_hop);
      end
    end
  end

  initial begin
    #(LIMIT_TICKS);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    adv_valid      = 1'b0;
    adv            = '0;
    result_ready   = 1'b0;
    rt_count       = 0;
    mismatch_count = 0;
    stall_left     = 0;
    quiet          = 1'b0;

    // empty table: self route, saturation, address extremes
    add_row(mk_req(dvru_pkg::KIND_ADVERT, 32'h0A00_0001, 32'hC0A8_0001, 32'h0A00_0001, 8'd7),
            1, mk_res(dvru_pkg::ST_INSERTED, 4'd0, 8'd1, 32'h0A00_0001));
    add_row(mk_req(dvru_pkg::KIND_ADVERT, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 8'd255),
            1, mk_res(dvru_pkg::ST_INSERTED, 4'd1, 8'd255, 32'h0000_0000));
    add_row(mk_req(dvru_pkg::KIND_ADVERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 8'd0),
            1, mk_res(dvru_pkg::ST_INSERTED, 4'd2, 8'd1, 32'hFFFF_FFFF));
    // relaxation: no gain, gain, worse cost from current next hop, ties
    add_row(mk_req(dvru_pkg::KIND_ADVERT, 32'h1234_5678, 32'h0000_0001, 32'hFFFF_FFFF, 8'd254),
            1, mk_res(dvru_pkg::ST_UNCHANGED, 4'd1, 8'd255, 32'h0000_0000));
    add_row(mk_req(dvru_pkg::KIND_ADVERT, 32'h1234_5678, 32'h0000_0001, 32'hFFFF_FFFF, 8'd10),
            1, mk_res(dvru_pkg::ST_UPDATED, 4'd1, 8'd11, 32'h1234_5678));
    add_row(mk_req(dvru_pkg::KIND_ADVERT, 32'h1234_5678, 32'h0000_0002, 32'hFFFF_FFFF, 8'd200),
            1, mk_res(dvru_pkg::ST_UPDATED, 4'd1, 8'd201, 32'h1234_5678));
    add_row(mk_req(dvru_pkg::KIND_ADVERT, 32'h0000_0055, 32'h0000_0003, 32'hFFFF_FFFF, 8'd200),
            1, mk_res(dvru_pkg::ST_UNCHANGED, 4'd1, 8'd201, 32'h1234_5678));
    add_row(mk_req(dvru_pkg::KIND_ADVERT, 32'h0000_0055, 32'h0000_0003, 32'hFFFF_FFFF, 8'd199),
            1, mk_res(dvru_pkg::ST_UPDATED, 4'd1, 8'd200, 32'h0000_0055));
    // local install over an existing route and into a new slot
    add_row(mk_req(dvru_pkg::KIND_INSTALL, 32'h0BAD_F00D, 32'h0000_0000, 32'h0000_0000, 8'd0),
            1, mk_res(dvru_pkg::ST_UPDATED, 4'd2, 8'd0, 32'h0BAD_F00D));
    add_row(mk_req(dvru_pkg::KIND_INSTALL, 32'h0000_0001, 32'hAAAA_AAAA, 32'h8000_0000, 8'd255),
            1, mk_res(dvru_pkg::ST_INSERTED, 4'd3, 8'd255, 32'h0000_0001));
    add_row(mk_req(dvru_pkg::KIND_ADVERT, 32'h0000_0001, 32'h5555_5555, 32'h8000_0000, 8'd255),
            1, mk_res(dvru_pkg::ST_UPDATED, 4'd3, 8'd255, 32'h0000_0001));
    add_row(mk_req(dvru_pkg::KIND_ADVERT, 32'h0BAD_F00D, 32'h0000_0004, 32'h0000_0000, 8'd255),
            1, mk_res(dvru_pkg::ST_UPDATED, 4'd2, 8'd255, 32'h0BAD_F00D));
    // fill the remaining slots
    for (int k = 0; k < DEPTH - 4; k++)
      add_row(mk_req(k[0] ? dvru_pkg::KIND_INSTALL : dvru_pkg::KIND_ADVERT,
                     32'h0A00_0000 + k, 32'hC0A8_0001, 32'h0000_0100 + k, 8'(k * 20)),
              0, '0);
    // full table: append of either kind is refused
    add_row(mk_req(dvru_pkg::KIND_ADVERT, 32'h0A00_0009, 32'h0000_0005, 32'h7FFF_FFFF, 8'd3),
            1, mk_res(dvru_pkg::ST_FULL, 4'd0, 8'd0, 32'h0000_0000));
    add_row(mk_req(dvru_pkg::KIND_INSTALL, 32'h0A00_0009, 32'h0000_0005, 32'hDEAD_BEEF, 8'd3),
            1, mk_res(dvru_pkg::ST_FULL, 4'd0, 8'd0, 32'h0000_0000));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (stim_rows[i]) send_req(stim_rows[i].req, stim_rows[i].typed, stim_rows[i].want);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      // hold off now and then until the block has drained
      if (n % 300 == 0) begin
        adv_valid <= 1'b0;
        wait (pending_routes.size() == 0);
        @(negedge clk);
      end
      quiet = (n >= 900 && n < 1100);
      send_req(random_req(), 0, '0);
    end
    adv_valid <= 1'b0;
    quiet = 1'b0;

    wait (pending_routes.size() == 0);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
design/dvru_pkg.sv
design/dvru_front.sv
design/dvru_back.sv
design/distance_vector_route_update.sv
dv/testbench.sv
